>>> rtl/core/bvm_pkg.sv
// Package for the battery voltage monitor: types, constants and helpers.
// Depends on nothing; every other file refers to it by scoped name.
`timescale 1ns / 1ps

package bvm_pkg;

    // Stream and register port widths
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 32;
    localparam int ADDR_W   = 4;
    localparam int PDATA_W  = 32;

    // Averaging
    localparam int SAMPLE_COUNT = 10;
    localparam int IDX_W        = 4;
    localparam logic [IDX_W:0] SAMPLE_COUNT_V = (IDX_W + 1)'(SAMPLE_COUNT);

    // Linear map of the averaged reading
    localparam logic signed [16:0] MAP_IN_LOW  = 17'sd1600;
    localparam int                 MAP_IN_HIGH = 1950;
    localparam logic [16:0]        MAP_IN_SPAN = 17'(MAP_IN_HIGH - 1600);

    // Percent and level
    localparam logic signed [7:0] PCT_SCALE = 8'sd100;
    localparam logic [6:0]        PCT_MAX   = 7'd100;
    localparam logic [6:0] LVL5_ABOVE = 7'd80;
    localparam logic [6:0] LVL4_ABOVE = 7'd60;
    localparam logic [6:0] LVL3_ABOVE = 7'd40;
    localparam logic [6:0] LVL2_ABOVE = 7'd20;
    localparam logic [6:0] LVL1_FROM  = 7'd5;

    // Shared divider geometry: numerator is left aligned in DIV_NUM_W bits
    localparam int DIV_NUM_W = 32;
    localparam int DIV_DEN_W = 17;
    localparam int DIV_CNT_W = 6;
    localparam logic [DIV_CNT_W-1:0] AVG_BITS = 6'd16;
    localparam logic [DIV_CNT_W-1:0] MAP_BITS = 6'd32;
    localparam logic [DIV_CNT_W-1:0] PCT_BITS = 6'd23;

    // Register map (word index) and reset values
    localparam logic [1:0] REG_VOLT_LO   = 2'd0;
    localparam logic [1:0] REG_VOLT_HI   = 2'd1;
    localparam logic [1:0] REG_OFFSET    = 2'd2;
    localparam logic [1:0] REG_PERIOD    = 2'd3;
    localparam logic [15:0] VOLT_LO_RST  = 16'd3600;
    localparam logic [15:0] VOLT_HI_RST  = 16'd4200;
    localparam logic [15:0] OFFSET_RST   = 16'd0;
    localparam logic [23:0] PERIOD_RST   = 24'd1000000;

    typedef struct packed {
        logic [15:0]        volt_lo;
        logic [15:0]        volt_hi;
        logic signed [15:0] volt_offset;
        logic [23:0]        sample_period_us;
    } cfg_t;

    typedef struct packed {
        logic                  start;
        logic [DIV_NUM_W-1:0]  num;
        logic [DIV_DEN_W-1:0]  den;
        logic [DIV_CNT_W-1:0]  nbits;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic [DIV_NUM_W-1:0] quot;
    } div_rsp_t;

    typedef struct packed {
        logic        shutdown;
        logic        new_average;
        logic [2:0]  level;
        logic [6:0]  percent;
        logic [15:0] voltage;
    } res_t;

    typedef enum logic [10:0] {
        ST_IDLE = 11'b000_0000_0001,
        ST_ACC  = 11'b000_0000_0010,
        ST_AVG  = 11'b000_0000_0100,
        ST_MMUL = 11'b000_0000_1000,
        ST_MDIV = 11'b000_0001_0000,
        ST_MAP  = 11'b000_0010_0000,
        ST_VOLT = 11'b000_0100_0000,
        ST_PMUL = 11'b000_1000_0000,
        ST_PDIV = 11'b001_0000_0000,
        ST_PCT  = 11'b010_0000_0000,
        ST_DONE = 11'b100_0000_0000
    } state_t;

    function automatic logic [2:0] pct_to_level(input logic [6:0] p);
        logic [2:0] lv;
        if (p > LVL5_ABOVE)      lv = 3'd5;
        else if (p > LVL4_ABOVE) lv = 3'd4;
        else if (p > LVL3_ABOVE) lv = 3'd3;
        else if (p > LVL2_ABOVE) lv = 3'd2;
        else if (p >= LVL1_FROM) lv = 3'd1;
        else                     lv = 3'd0;
        return lv;
    endfunction

endpackage

>>> rtl/core/bvm_cfg.sv
// Configuration register file behind the APB-style port.
// Depends on bvm_pkg.
`timescale 1ns / 1ps

module bvm_cfg (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bvm_pkg::ADDR_W-1:0]   paddr,
    input  logic [bvm_pkg::PDATA_W-1:0]  pwdata,
    output logic [bvm_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    output bvm_pkg::cfg_t                cfg
);

    logic [15:0] volt_lo_reg;
    logic [15:0] volt_hi_reg;
    logic [15:0] offset_reg;
    logic [23:0] period_reg;
    logic        wr_en;
    logic [1:0]  reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            volt_lo_reg  <= bvm_pkg::VOLT_LO_RST;
            volt_hi_reg  <= bvm_pkg::VOLT_HI_RST;
            offset_reg   <= bvm_pkg::OFFSET_RST;
            period_reg   <= bvm_pkg::PERIOD_RST;
        end else if (wr_en) begin
            case (reg_idx)
                bvm_pkg::REG_VOLT_LO:  volt_lo_reg  <= pwdata[15:0];
                bvm_pkg::REG_VOLT_HI:  volt_hi_reg  <= pwdata[15:0];
                bvm_pkg::REG_OFFSET:   offset_reg   <= pwdata[15:0];
                bvm_pkg::REG_PERIOD:   period_reg   <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            bvm_pkg::REG_VOLT_LO:  prdata = {16'd0, volt_lo_reg};
            bvm_pkg::REG_VOLT_HI:  prdata = {16'd0, volt_hi_reg};
            bvm_pkg::REG_OFFSET:   prdata = {16'd0, offset_reg};
            bvm_pkg::REG_PERIOD:   prdata = {8'd0, period_reg};
            default:               prdata = '0;
        endcase
    end

    assign cfg.volt_lo          = volt_lo_reg;
    assign cfg.volt_hi          = volt_hi_reg;
    assign cfg.volt_offset      = $signed(offset_reg);
    assign cfg.sample_period_us = period_reg;

endmodule

>>> rtl/core/bvm_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Numerator arrives left aligned; nbits steps leave the quotient in the low bits.
// Depends on bvm_pkg.
`timescale 1ns / 1ps

module bvm_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  bvm_pkg::div_req_t req,
    output bvm_pkg::div_rsp_t rsp
);

    logic                           busy_reg;
    logic                           done_reg;
    logic [bvm_pkg::DIV_CNT_W-1:0]  cnt_reg;
    logic [bvm_pkg::DIV_DEN_W-1:0]  den_reg;
    logic [bvm_pkg::DIV_DEN_W-1:0]  rem_reg;
    logic [bvm_pkg::DIV_NUM_W-1:0]  quo_reg;

    logic [bvm_pkg::DIV_DEN_W:0]    trial;
    logic [bvm_pkg::DIV_DEN_W:0]    diff;
    logic                           fits;
    logic [bvm_pkg::DIV_DEN_W-1:0]  rem_next;

    assign trial    = {rem_reg, quo_reg[bvm_pkg::DIV_NUM_W-1]};
    assign diff     = trial - {1'b0, den_reg};
    assign fits     = trial >= {1'b0, den_reg};
    assign rem_next = fits ? diff[bvm_pkg::DIV_DEN_W-1:0] : trial[bvm_pkg::DIV_DEN_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= ~req.start & busy_reg & (cnt_reg == bvm_pkg::DIV_CNT_W'(1));
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.nbits;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == bvm_pkg::DIV_CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // Datapath: load on start, shift one quotient bit in per busy cycle
    always_ff @(posedge aclk) begin
        if (req.start) begin
            den_reg <= req.den;
            rem_reg <= '0;
            quo_reg <= req.num;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[bvm_pkg::DIV_NUM_W-2:0], fits};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quo_reg;

endmodule

>>> rtl/core/bvm_core.sv
// Tick sequencer: time accumulation, sample averaging, voltage map, percent.
// Drives the shared divider; depends on bvm_pkg.
`timescale 1ns / 1ps

module bvm_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  bvm_pkg::cfg_t     cfg,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [19:0]       in_elapsed,
    input  logic [11:0]       in_adc,
    input  logic              in_charger,
    output logic              res_valid,
    input  logic              res_ready,
    output bvm_pkg::res_t     res,
    output bvm_pkg::div_req_t div_req,
    input  bvm_pkg::div_rsp_t div_rsp
);

    bvm_pkg::state_t state_reg;

    logic [31:0]                 time_accum_reg;
    logic [15:0]                 sum_reg;
    logic [bvm_pkg::IDX_W-1:0]   idx_reg;
    logic [15:0]                 stored_reg;
    logic [11:0]                 adc_reg;
    logic                        chg_reg;
    logic                        fresh_reg;
    logic                        neg_reg;
    logic signed [16:0]          diff_reg;
    logic signed [33:0]          prod_reg;
    logic [15:0]                 volts_reg;
    logic signed [23:0]          pprod_reg;
    logic [6:0]                  pct_reg;

    logic                        hit;
    logic                        last;
    logic [15:0]                 sum_new;
    logic signed [16:0]          span;
    logic [16:0]                 span_mag;
    logic [33:0]                 prod_mag;
    logic [23:0]                 pprod_mag;
    logic signed [33:0]          qs;
    logic signed [33:0]          map_v;
    logic signed [16:0]          vdiff;

    assign hit      = time_accum_reg >= {8'd0, cfg.sample_period_us};
    assign last     = ({1'b0, idx_reg} + 1'b1) >= bvm_pkg::SAMPLE_COUNT_V;
    assign sum_new  = sum_reg + {4'd0, adc_reg};
    assign span     = $signed({1'b0, cfg.volt_hi}) - $signed({1'b0, cfg.volt_lo});
    assign span_mag = span[16] ? 17'(-span) : 17'(span);
    assign prod_mag = prod_reg[33] ? 34'(-prod_reg) : 34'(prod_reg);
    assign pprod_mag = pprod_reg[23] ? 24'(-pprod_reg) : 24'(pprod_reg);
    assign qs       = neg_reg ? -$signed({2'b00, div_rsp.quot})
                              : $signed({2'b00, div_rsp.quot});
    assign map_v    = qs + $signed({18'd0, cfg.volt_lo});
    assign vdiff    = $signed({1'b0, volts_reg}) - $signed({1'b0, cfg.volt_lo});

    assign in_ready  = (state_reg == bvm_pkg::ST_IDLE);
    assign res_valid = (state_reg == bvm_pkg::ST_DONE);

    // Divider requests
    always_comb begin
        div_req = '0;
        case (state_reg)
            bvm_pkg::ST_ACC: begin
                if (hit && last) begin
                    div_req.start = 1'b1;
                    div_req.num   = {sum_new, 16'd0};
                    div_req.den   = bvm_pkg::DIV_DEN_W'(bvm_pkg::SAMPLE_COUNT);
                    div_req.nbits = bvm_pkg::AVG_BITS;
                end
            end
            bvm_pkg::ST_MDIV: begin
                div_req.start = 1'b1;
                div_req.num   = prod_mag[31:0];
                div_req.den   = bvm_pkg::MAP_IN_SPAN;
                div_req.nbits = bvm_pkg::MAP_BITS;
            end
            bvm_pkg::ST_PDIV: begin
                if (span != 17'sd0) begin
                    div_req.start = 1'b1;
                    div_req.num   = {pprod_mag[22:0], 9'd0};
                    div_req.den   = span_mag;
                    div_req.nbits = bvm_pkg::PCT_BITS;
                end
            end
            default: ;
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= bvm_pkg::ST_IDLE;
            time_accum_reg <= '0;
            sum_reg        <= '0;
            idx_reg        <= '0;
            stored_reg     <= '0;
            fresh_reg      <= 1'b0;
        end else begin
            case (state_reg)
                bvm_pkg::ST_IDLE: begin
                    if (in_valid) begin
                        time_accum_reg <= time_accum_reg + {12'd0, in_elapsed};
                        fresh_reg      <= 1'b0;
                        state_reg      <= bvm_pkg::ST_ACC;
                    end
                end
                bvm_pkg::ST_ACC: begin
                    if (hit) begin
                        time_accum_reg <= '0;
                        if (last) begin
                            sum_reg   <= '0;
                            idx_reg   <= '0;
                            fresh_reg <= 1'b1;
                            state_reg <= bvm_pkg::ST_AVG;
                        end else begin
                            sum_reg   <= sum_new;
                            idx_reg   <= idx_reg + 1'b1;
                            state_reg <= bvm_pkg::ST_VOLT;
                        end
                    end else begin
                        state_reg <= bvm_pkg::ST_VOLT;
                    end
                end
                bvm_pkg::ST_AVG: begin
                    if (div_rsp.done) state_reg <= bvm_pkg::ST_MMUL;
                end
                bvm_pkg::ST_MMUL: state_reg <= bvm_pkg::ST_MDIV;
                bvm_pkg::ST_MDIV: state_reg <= bvm_pkg::ST_MAP;
                bvm_pkg::ST_MAP: begin
                    if (div_rsp.done) begin
                        if (map_v < 34'sd0)          stored_reg <= 16'd0;
                        else if (map_v > 34'sd65535) stored_reg <= 16'hFFFF;
                        else                         stored_reg <= map_v[15:0];
                        state_reg <= bvm_pkg::ST_VOLT;
                    end
                end
                bvm_pkg::ST_VOLT: state_reg <= bvm_pkg::ST_PMUL;
                bvm_pkg::ST_PMUL: state_reg <= bvm_pkg::ST_PDIV;
                bvm_pkg::ST_PDIV: begin
                    state_reg <= (span == 17'sd0) ? bvm_pkg::ST_DONE : bvm_pkg::ST_PCT;
                end
                bvm_pkg::ST_PCT: begin
                    if (div_rsp.done) state_reg <= bvm_pkg::ST_DONE;
                end
                bvm_pkg::ST_DONE: begin
                    if (res_ready) state_reg <= bvm_pkg::ST_IDLE;
                end
                default: state_reg <= bvm_pkg::ST_IDLE;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            bvm_pkg::ST_IDLE: begin
                adc_reg <= in_adc;
                chg_reg <= in_charger;
            end
            bvm_pkg::ST_AVG: begin
                diff_reg <= $signed({1'b0, div_rsp.quot[15:0]}) - bvm_pkg::MAP_IN_LOW;
            end
            bvm_pkg::ST_MMUL: prod_reg <= diff_reg * span;
            bvm_pkg::ST_MDIV: neg_reg <= prod_reg[33];
            bvm_pkg::ST_VOLT: volts_reg <= stored_reg + cfg.volt_offset;
            bvm_pkg::ST_PMUL: pprod_reg <= vdiff * bvm_pkg::PCT_SCALE;
            bvm_pkg::ST_PDIV: begin
                neg_reg <= pprod_reg[23] ^ span[16];
                pct_reg <= 7'd0;
            end
            bvm_pkg::ST_PCT: begin
                if (neg_reg)
                    pct_reg <= 7'd0;
                else if (div_rsp.quot > {25'd0, bvm_pkg::PCT_MAX})
                    pct_reg <= bvm_pkg::PCT_MAX;
                else
                    pct_reg <= div_rsp.quot[6:0];
            end
            default: ;
        endcase
    end

    assign res.voltage     = volts_reg;
    assign res.percent     = pct_reg;
    assign res.level       = bvm_pkg::pct_to_level(pct_reg);
    assign res.new_average = fresh_reg;
    assign res.shutdown    = fresh_reg & (volts_reg < cfg.volt_lo) & ~chg_reg;

endmodule

>>> rtl/core/battery_voltage_monitor_unit.sv
// Battery voltage monitor top level: config port, sequencer, shared divider, output register.
// The divider makes passes of 16, 32 and 23 steps for the average, the voltage map and the
//   percent; with equal limits the percent pass is skipped.
// A new word is taken only once the last result is handed on; a stalled result word holds s_tready.
// Reset: aresetn, synchronous and active low, clears accumulators, stored voltage, sequencer and
//   output register, reloads register defaults. Depends on bvm_pkg, bvm_cfg, bvm_div, bvm_core.
`timescale 1ns / 1ps

module battery_voltage_monitor_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Input stream, s_tdata: elapsed_us[19:0], adc_sample[31:20], charger_on[32], zero fill
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [bvm_pkg::S_DATA_W-1:0]  s_tdata,
    // Result stream, m_tdata: voltage[15:0], percent[22:16], level[25:23],
    // new_average[26], shutdown[27], zero fill
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [bvm_pkg::M_DATA_W-1:0]  m_tdata,
    // Configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bvm_pkg::ADDR_W-1:0]    paddr,
    input  logic [bvm_pkg::PDATA_W-1:0]   pwdata,
    output logic [bvm_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

    bvm_pkg::cfg_t     cfg;
    bvm_pkg::div_req_t div_req;
    bvm_pkg::div_rsp_t div_rsp;
    bvm_pkg::res_t     res;
    bvm_pkg::res_t     out_reg;
    logic              out_valid_reg;
    logic              res_valid;
    logic              slot_free;

    // Register file: min/max volts, offset, sample period
    bvm_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Shared divider: average, voltage map and percent all go through it
    bvm_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // Sequencer and tick state; takes one word, hands one result
    bvm_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_elapsed (s_tdata[19:0]),
        .in_adc     (s_tdata[31:20]),
        .in_charger (s_tdata[32]),
        .res_valid  (res_valid),
        .res_ready  (slot_free),
        .res        (res),
        .div_req    (div_req),
        .div_rsp    (div_rsp)
    );

    // Output register: load when empty or being drained, hold while stalled
    assign slot_free = ~out_valid_reg | m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (slot_free) begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (slot_free && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_reg};

    // A finished result lands in the output register on the next edge
    a_result_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && slot_free) |=> m_tvalid)
        else $error("result not presented after load");

    // The sequencer drops ready right after taking a word
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while sequencer busy");

    // Percent stays clamped
    a_pct_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (out_reg.percent <= bvm_pkg::PCT_MAX))
        else $error("percent above full scale");

    // Shutdown only on a tick that closed an average
    a_shutdown_fresh: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_reg.shutdown) |-> out_reg.new_average)
        else $error("shutdown without new average");

endmodule

>>> test/battery_voltage_monitor_unit_tb.sv
// Testbench for battery_voltage_monitor_unit: drives tick words and register writes,
// predicts every result word and checks it field by field. Depends on bvm_pkg and the RTL.
`timescale 1ns / 1ps

module battery_voltage_monitor_unit_tb;

    // Averaging and map constants of the monitor
    localparam int AVG_COUNT = bvm_pkg::SAMPLE_COUNT;
    localparam int MAP_LO    = 1600;
    localparam int MAP_HI    = 1950;
    localparam int ELAPSED_MAX = 1048575;

    logic                          aclk     = 1'b0;
    logic                          aresetn  = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    // s_tdata: elapsed_us[19:0], adc_sample[31:20], charger_on[32], zero fill
    logic [bvm_pkg::S_DATA_W-1:0]  s_tdata  = '0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    // m_tdata: voltage[15:0], percent[22:16], level[25:23], new_average[26], shutdown[27]
    logic [bvm_pkg::M_DATA_W-1:0]  m_tdata;
    logic                          psel     = 1'b0;
    logic                          penable  = 1'b0;
    logic                          pwrite   = 1'b0;
    logic [bvm_pkg::ADDR_W-1:0]    paddr    = '0;
    logic [bvm_pkg::PDATA_W-1:0]   pwdata   = '0;
    logic [bvm_pkg::PDATA_W-1:0]   prdata;
    logic                          pready;

    battery_voltage_monitor_unit uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // 2 ns clock
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Shadow copy of the monitor's registers
    logic [15:0]        cfg_min    = bvm_pkg::VOLT_LO_RST;
    logic [15:0]        cfg_max    = bvm_pkg::VOLT_HI_RST;
    logic signed [15:0] cfg_offset = bvm_pkg::OFFSET_RST;
    logic [23:0]        cfg_period = bvm_pkg::PERIOD_RST;

    // Shadow copy of the monitor's running state
    logic [31:0] acc_us        = '0;
    logic [15:0] adc_total     = '0;
    logic [3:0]  samples_taken = '0;
    logic [15:0] held_volts    = '0;

    bvm_pkg::res_t expected_results[$];

    // When set, neither side idles: a stretch of back-to-back words
    logic steady = 1'b0;

    int fail_count     = 0;
    int ticks_sent     = 0;
    int averages_seen  = 0;
    int shutdowns_seen = 0;
    int settings_used  = 0;

    // Bars for a percentage
    function automatic logic [2:0] bars_for(input logic [6:0] pct);
        if (pct > 7'd80) return 3'd5;
        if (pct > 7'd60) return 3'd4;
        if (pct > 7'd40) return 3'd3;
        if (pct > 7'd20) return 3'd2;
        if (pct >= 7'd5) return 3'd1;
        return 3'd0;
    endfunction

    // Advance the shadow state by one tick and return the result word it must produce
    function automatic bvm_pkg::res_t predict_tick(input logic [19:0] elapsed,
                                                   input logic [11:0] adc,
                                                   input logic charging);
        bvm_pkg::res_t r;
        logic          fresh;
        longint        span;
        longint        mapped;
        longint        pct;
        logic [15:0]   avg;
        logic [15:0]   volts;
        fresh = 1'b0;
        span  = longint'(cfg_max) - longint'(cfg_min);
        acc_us = acc_us + 32'(elapsed);
        if (acc_us >= 32'(cfg_period)) begin
            acc_us    = '0;
            adc_total = adc_total + 16'(adc);
            if (int'(samples_taken) + 1 >= AVG_COUNT) begin
                avg    = adc_total / 16'(AVG_COUNT);
                // map truncates toward zero, then saturates to 16 bits
                mapped = (longint'(avg) - MAP_LO) * span / (MAP_HI - MAP_LO)
                         + longint'(cfg_min);
                if (mapped < 0) mapped = 0;
                if (mapped > 65535) mapped = 65535;
                held_volts    = 16'(mapped);
                adc_total     = '0;
                samples_taken = '0;
                fresh         = 1'b1;
            end else begin
                samples_taken = samples_taken + 4'd1;
            end
        end
        volts = held_volts + cfg_offset;
        if (span == 0) begin
            pct = 0;
        end else begin
            pct = (longint'(volts) - longint'(cfg_min)) * 100 / span;
            if (pct < 0) pct = 0;
            if (pct > 100) pct = 100;
        end
        r.voltage     = volts;
        r.percent     = 7'(pct);
        r.level       = bars_for(7'(pct));
        r.new_average = fresh;
        r.shutdown    = fresh && (volts < cfg_min) && !charging;
        return r;
    endfunction

    // Send one tick word; the prediction is taken at the edge that accepts it.
    // s_tvalid stays high afterward, so callers that let time pass must drop it first.
    task automatic send_tick(input logic [19:0] elapsed, input logic [11:0] adc,
                             input logic charging);
        while (!steady && $urandom_range(0, 99) < 21) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tdata  <= {7'd0, charging, adc, elapsed};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        expected_results.push_back(predict_tick(elapsed, adc, charging));
        ticks_sent++;
    endtask

    // Drop valid and hold until every expected word has come back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // One register write: setup cycle, then access cycle until pready.
    // The bus stays selected afterward; the caller idles it.
    task automatic reg_write(input logic [1:0] idx, input logic [bvm_pkg::PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
    endtask

    // Write all four registers; only called with the monitor idle
    task automatic set_config(input logic [15:0] lo, input logic [15:0] hi,
                              input logic [15:0] off, input logic [23:0] period);
        reg_write(bvm_pkg::REG_VOLT_LO, 32'(lo));
        reg_write(bvm_pkg::REG_VOLT_HI, 32'(hi));
        reg_write(bvm_pkg::REG_OFFSET, 32'(off));
        reg_write(bvm_pkg::REG_PERIOD, 32'(period));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cfg_min    = lo;
        cfg_max    = hi;
        cfg_offset = off;
        cfg_period = period;
        settings_used++;
    endtask

    // Random tick: mostly elapsed times on either side of the sample period, readings near the map range
    task automatic random_tick();
        int          cap;
        int          pick;
        logic [19:0] elapsed;
        logic [11:0] adc;
        cap  = (cfg_period > 24'(ELAPSED_MAX)) ? ELAPSED_MAX : int'(cfg_period);
        pick = $urandom_range(0, 9);
        if (pick < 4)
            elapsed = 20'($urandom_range(0, cap));
        else if (pick < 8)
            elapsed = 20'($urandom_range(cap, ELAPSED_MAX));
        else
            elapsed = 20'($urandom);
        if ($urandom_range(0, 9) < 7)
            adc = 12'($urandom_range(1550, 2000));
        else
            adc = 12'($urandom);
        send_tick(elapsed, adc, 1'($urandom));
    endtask

    // Reset values: no-sample ticks, the period boundary, then one full average
    task automatic test_directed_defaults();
        send_tick(20'd0, 12'd0, 1'b0);
        send_tick(20'd999999, 12'hFFF, 1'b1);
        send_tick(20'd1, 12'd0, 1'b0);
        for (int i = 0; i < AVG_COUNT - 1; i++)
            send_tick(20'hFFFFF, (i % 2 == 0) ? 12'hFFF : 12'd1600, 1'(i));
        wait_drained();
    endtask

    // Equal limits give a zero percentage; zero period samples every tick;
    // a negative offset pulls the average below the minimum and trips shutdown
    task automatic test_directed_equal_limits();
        set_config(16'd4000, 16'd4000, 16'hFF9C, 24'd0);
        for (int i = 0; i < AVG_COUNT; i++)
            send_tick(20'd0, 12'(1000 + i), 1'b0);
        wait_drained();
    endtask

    // Several register settings, the extremes among them, with random ticks under each
    task automatic test_random_settings();
        logic [15:0] lo;
        logic [15:0] hi;
        logic [15:0] off;
        logic [23:0] period;
        int          count;
        for (int phase = 0; phase < 9; phase++) begin
            count = 110;
            case (phase)
                0: begin lo = 16'd3600; hi = 16'd4200; off = 16'd0; period = 24'd500; end
                1: begin lo = 16'd0; hi = 16'hFFFF; off = 16'h7FFF; period = 24'd1; end
                2: begin
                    lo = 16'hFFFF; hi = 16'd0; off = 16'h8000;
                    period = 24'($urandom_range(1, 2000));
                end
                3: begin
                    lo = 16'($urandom); hi = lo; off = 16'($urandom); period = 24'd100;
                end
                4: begin
                    lo = 16'($urandom); hi = 16'($urandom); off = 16'($urandom);
                    period = 24'($urandom_range(1, ELAPSED_MAX));
                end
                5: begin
                    // samples are rare here: keep the phase short
                    lo = 16'd3000; hi = 16'd4200; off = 16'hFDA8; period = 24'hFFFFFF;
                    count = 60;
                end
                6: begin
                    lo = 16'd3600; hi = 16'd4200;
                    off = 16'($signed($urandom_range(0, 600)) - 300); period = 24'd0;
                end
                7: begin lo = 16'd4200; hi = 16'd3600; off = 16'd0; period = 24'd1000; end
                default: begin
                    lo = 16'd0; hi = 16'd1; off = 16'($urandom); period = 24'd10;
                end
            endcase
            set_config(lo, hi, off, period);
            for (int i = 0; i < count; i++) begin
                // hold the sender once per setting until the pipe is empty
                if (i == count / 2) wait_drained();
                random_tick();
            end
            wait_drained();
        end
    endtask

    // Back-to-back words on both sides, no idling at all
    task automatic test_steady_stream();
        set_config(16'd3500, 16'd4150, 16'd40, 24'd250);
        steady = 1'b1;
        for (int i = 0; i < 150; i++)
            random_tick();
        wait_drained();
        steady = 1'b0;
    endtask

    // Result side: stall at random unless in the steady stretch
    always @(posedge aclk) begin
        m_tready <= steady || ($urandom_range(0, 99) >= 21);
    end

    // Compare each accepted result word with the oldest prediction
    always @(posedge aclk) begin
        bvm_pkg::res_t got;
        bvm_pkg::res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = bvm_pkg::res_t'(m_tdata[27:0]);
            if (expected_results.size() == 0) begin
                $error("result word %h arrived with nothing expected", m_tdata);
                fail_count++;
            end else begin
                want = expected_results.pop_front();
                if (got.voltage !== want.voltage) begin
                    $error("voltage: expected %0d, got %0d", want.voltage, got.voltage);
                    fail_count++;
                end
                if (got.percent !== want.percent) begin
                    $error("percent: expected %0d, got %0d", want.percent, got.percent);
                    fail_count++;
                end
                if (got.level !== want.level) begin
                    $error("level: expected %0d, got %0d", want.level, got.level);
                    fail_count++;
                end
                if (got.new_average !== want.new_average) begin
                    $error("new_average: expected %0d, got %0d",
                           want.new_average, got.new_average);
                    fail_count++;
                end
                if (got.shutdown !== want.shutdown) begin
                    $error("shutdown: expected %0d, got %0d", want.shutdown, got.shutdown);
                    fail_count++;
                end
                if (want.new_average) averages_seen++;
                if (want.shutdown) shutdowns_seen++;
            end
        end
    end

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_defaults();
        test_directed_equal_limits();
        test_random_settings();
        test_steady_stream();
        wait_drained();
        repeat (100) @(posedge aclk);
        $display("Covered %0d ticks under %0d register settings plus reset values;",
                 ticks_sent, settings_used);
        $display("  %0d new averages and %0d shutdown flags checked.",
                 averages_seen, shutdowns_seen);
        if (fail_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run
    initial begin
        #2000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
